@@ rtl/polar_pose_controller_defines.svh @@
// Assertion macros for the pose controller top level.
`ifndef POLAR_POSE_CONTROLLER_DEFINES_SVH
`define POLAR_POSE_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define PPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ppc_pkg.sv @@
// Package with types and constants of the pose controller.
`timescale 1ns / 1ps
`default_nettype none
package ppc_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CORDIC,
        ST_MUL,
        ST_OUT
    } state_t;

    localparam logic [1:0] REG_KP  = 2'd0;
    localparam logic [1:0] REG_KA  = 2'd1;
    localparam logic [1:0] REG_KB  = 2'd2;
    localparam logic [1:0] REG_TOL = 2'd3;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                5'd0:  r = 34'sd843314857;
                5'd1:  r = 34'sd497837829;
                5'd2:  r = 34'sd263043836;
                5'd3:  r = 34'sd133525159;
                5'd4:  r = 34'sd67021687;
                5'd5:  r = 34'sd33543516;
                5'd6:  r = 34'sd16775851;
                5'd7:  r = 34'sd8388437;
                5'd8:  r = 34'sd4194283;
                5'd9:  r = 34'sd2097149;
                5'd10: r = 34'sd1048576;
                default: r = 34'sd1 <<< (5'd30 - i);
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/ppc_sqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ppc_sqrt
    import ppc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [35:0] radicand,
    output logic             done,
    output logic [17:0]      root
);
    logic [35:0] n_reg, n_next;
    logic [19:0] rem_reg, rem_next;
    logic [17:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [19:0] trial;

    // One restoring step per cycle.
    always_comb
    begin
        n_next = n_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[17:0], n_reg[35:34]} - {q_reg, 2'b01};
        if (start)
        begin
            n_next = radicand;
            rem_next = '0;
            q_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[33:0], 2'b00};
            if (!trial[19])
            begin
                rem_next = trial;
                q_next = {q_reg[16:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[17:0], n_reg[35:34]};
                q_next = {q_reg[16:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd17)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
    end

    assign done = busy_reg && (cnt_reg == 5'd17);
    assign root = q_next;
endmodule
`default_nettype wire

@@ rtl/ppc_cordic.sv @@
// Iterative CORDIC vectoring unit giving atan2 in Q30 radians.
`timescale 1ns / 1ps
`default_nettype none
module ppc_cordic
    import ppc_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [17:0] dx,
    input  wire logic signed [17:0] dy,
    output logic                    done,
    output logic signed [33:0]      angle
);
    localparam logic signed [33:0] HALF_PI = 34'sd1686629713;
    logic signed [37:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [4:0] i_reg, i_next;
    logic busy_reg, busy_next;
    logic signed [37:0] xi, yi;

    // One micro-rotation per cycle.
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        xi = {{4{dx[17]}}, dx, 16'd0};
        yi = {{4{dy[17]}}, dy, 16'd0};
        if (start)
        begin
            x_next = xi;
            y_next = yi;
            z_next = '0;
            i_next = '0;
            busy_next = 1'b1;
            if (xi < 0)
            begin
                if (yi >= 0)
                begin
                    x_next = yi;
                    y_next = -xi;
                    z_next = HALF_PI;
                end
                else
                begin
                    x_next = -yi;
                    y_next = xi;
                    z_next = -HALF_PI;
                end
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + (y_reg >>> i_reg);
                y_next = y_reg - (x_reg >>> i_reg);
                z_next = z_reg + atan_q30(i_reg);
            end
            else
            begin
                x_next = x_reg - (y_reg >>> i_reg);
                y_next = y_reg + (x_reg >>> i_reg);
                z_next = z_reg - atan_q30(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(STEPS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            i_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done = busy_reg && (i_reg == 5'(STEPS - 1));
    assign angle = z_next;
endmodule
`default_nettype wire

@@ rtl/polar_pose_controller.sv @@
// Top level of the polar-coordinate pose controller.
`timescale 1ns / 1ps
`default_nettype none
`include "polar_pose_controller_defines.svh"
// Takes one odometry word (x and y in Q3.12, heading in Q2.12) and returns one
// command word. The square root works through the word bit-serially. The atan2
// unit runs its CORDIC_STEPS iterations alongside it, and the longer of the two
// sets the pace. At the default of 16 steps the square root is the longer one.
// Then come the angle wrap, the multiply, and the rounding and clamps, in the
// states ST_CORDIC, ST_MUL and ST_OUT. The next word can be accepted once the
// result has moved into the output register.
// Only one word is computed at a time. A finished result waits in the output
// register while the next word is accepted and computed. That word's result
// stalls in the last step only if the output register is still full.
module polar_pose_controller
    import ppc_pkg::*;
#(
    parameter int GOAL_COUNT   = 4,
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], heading[46:32]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // lin_vel[10:0], ang_vel[25:11], goal_index[27:26], arrived[28]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int IW = (GOAL_COUNT > 1) ? $clog2(GOAL_COUNT) : 1;
    localparam logic signed [17:0] PI_Q = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q = 18'sd25736;

    state_t state_reg, state_next;
    logic signed [15:0] kp_reg, ka_reg, kb_reg;
    logic [14:0] tol_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic signed [17:0] dx_reg, dy_reg, dth_reg, th_reg;
    logic [17:0] rho_reg;
    logic signed [17:0] alpha_reg, beta_reg;
    logic signed [35:0] pv_reg, pa_reg, pb_reg;
    logic sq_done_reg, co_done_reg;
    logic out_valid_reg;
    logic [31:0] out_data_reg;
    logic sq_done, co_done;
    logic [17:0] root;
    logic signed [33:0] angle;
    logic signed [17:0] gx, gy, gt, ax, ay, ath, at2, alpha_w, beta_raw, beta_w;
    logic signed [35:0] sqx, sqy;
    logic signed [37:0] vsum, wsum;
    logic signed [23:0] v, w;
    logic inside_xy, inside_th, arrive;
    logic start;
    logic out_load;

    // Goal table of the built-in waypoints.
    always_comb
    begin
        case (idx_reg)
            IW'(0): begin gx = 18'sd16384; gy = 18'sd0;     gt = 18'sd0;      end
            IW'(1): begin gx = 18'sd20480; gy = -18'sd8192; gt = -18'sd6434;  end
            IW'(2): begin gx = 18'sd16384; gy = -18'sd12288; gt = -18'sd12868; end
            default: begin gx = 18'sd4096; gy = -18'sd4096; gt = 18'sd12868;  end
        endcase
    end

    assign ax = {{2{s_axis_tdata[15]}}, s_axis_tdata[15:0]};
    assign ay = {{2{s_axis_tdata[31]}}, s_axis_tdata[31:16]};
    assign ath = {{3{s_axis_tdata[46]}}, s_axis_tdata[46:32]};
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign start = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign sqx = (gx - ax) * (gx - ax);
    assign sqy = (gy - ay) * (gy - ay);

    // The result moves into the output register once that register is empty or the receiver is ready.
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    ppc_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(start),
        .radicand(36'(sqx) + 36'(sqy)), .done(sq_done), .root(root)
    );

    ppc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(start && !((gx == ax) && (gy == ay))),
        .dx(gx - ax), .dy(gy - ay), .done(co_done), .angle(angle)
    );

    // Angle rounding and single wraps.
    assign at2 = ((dx_reg == 0) && (dy_reg == 0)) ? 18'sd0 :
        18'((angle + 34'sd131072) >>> 18);
    always_comb
    begin
        alpha_w = at2 - th_reg;
        if (alpha_w > PI_Q) alpha_w = alpha_w - TWO_PI_Q;
        if (alpha_w < -PI_Q) alpha_w = alpha_w + TWO_PI_Q;
        beta_raw = dth_reg - alpha_w;
        beta_w = beta_raw;
        if (beta_w > PI_Q) beta_w = beta_w - TWO_PI_Q;
        if (beta_w < -PI_Q) beta_w = beta_w + TWO_PI_Q;
    end

    // Rounding, clamps and arrival test.
    assign vsum = 38'(pv_reg) + 38'sd2048;
    assign wsum = 38'(pa_reg) + 38'(pb_reg) + 38'sd2048;
    always_comb
    begin
        v = 24'(vsum >>> 12);
        w = 24'(wsum >>> 12);
        if (v >= 24'sd860) v = 24'sd819;
        if (v <= -24'sd860) v = -24'sd819;
        if (w >= 24'sd9421) w = 24'sd8192;
        if (w <= -24'sd9421) w = -24'sd8192;
        inside_xy = (dx_reg > -$signed({3'b0, tol_reg})) && (dx_reg < $signed({3'b0, tol_reg}))
            && (dy_reg > -$signed({3'b0, tol_reg})) && (dy_reg < $signed({3'b0, tol_reg}));
        inside_th = (dth_reg > -$signed({2'b0, tol_reg, 1'b0}))
            && (dth_reg < $signed({2'b0, tol_reg, 1'b0}));
        arrive = inside_xy && inside_th;
        if (inside_xy) v = '0;
        if (arrive) w = '0;
        idx_next = idx_reg;
        if (arrive && (idx_reg != IW'(GOAL_COUNT - 1)))
            idx_next = idx_reg + IW'(1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_SQRT;
            ST_SQRT:   if ((sq_done || sq_done_reg) && (co_done || co_done_reg
                           || ((dx_reg == 0) && (dy_reg == 0)))) state_next = ST_CORDIC;
            ST_CORDIC: state_next = ST_MUL;
            ST_MUL:    state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kp_reg <= 16'sd1638;
            ka_reg <= 16'sd4096;
            kb_reg <= -16'sd1229;
            tol_reg <= 15'd410;
            idx_reg <= '0;
            sq_done_reg <= 1'b0;
            co_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KP:  kp_reg <= cfg_data;
                    REG_KA:  ka_reg <= cfg_data;
                    REG_KB:  kb_reg <= cfg_data;
                    REG_TOL: tol_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (start)
            begin
                sq_done_reg <= 1'b0;
                co_done_reg <= 1'b0;
            end
            else
            begin
                if (sq_done) sq_done_reg <= 1'b1;
                if (co_done) co_done_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg <= idx_next;
            end
            else if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dx_reg <= gx - ax;
            dy_reg <= gy - ay;
            dth_reg <= gt - ath;
            th_reg <= ath;
        end
        if (sq_done) rho_reg <= root;
        if (state_reg == ST_CORDIC)
        begin
            alpha_reg <= alpha_w;
            beta_reg <= beta_w;
        end
        if (state_reg == ST_MUL)
        begin
            pv_reg <= kp_reg * $signed({1'b0, rho_reg[16:0]});
            pa_reg <= ka_reg * alpha_reg;
            pb_reg <= kb_reg * beta_reg;
        end
        if (out_load)
            out_data_reg <= {3'b0, arrive, 2'(idx_next), w[14:0], v[10:0]};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    `PPC_ASSERT_IMPL(a_one_item, clk, rst_n, state_reg != ST_IDLE, !s_axis_tready)
    `PPC_ASSERT_NEXT(a_out_follows, clk, rst_n, state_reg == ST_OUT, m_axis_tvalid)
    `PPC_ASSERT_IMPL(a_idx_range, clk, rst_n, 1'b1, idx_reg <= IW'(GOAL_COUNT - 1))
endmodule
`default_nettype wire

@@ verif/polar_pose_controller_checker.sv @@
// Command checker for the pose controller: watches all channels, predicts and compares.
`timescale 1ns / 1ps
module polar_pose_controller_checker
    import ppc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], heading[46:32]
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,   // lin_vel[10:0], ang_vel[25:11], goal_index[27:26], arrived[28]
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               errors,
    output int               pending
);
    localparam longint PI_Q30    = 64'sd3373259426;
    localparam longint PI_Q      = 12868;
    localparam longint TWO_PI_Q  = 25736;
    localparam longint HALF_PI_Q = 6434;
    localparam longint V_TRIP    = 860;
    localparam longint V_SET     = 819;
    localparam longint W_TRIP    = 9421;
    localparam longint W_SET     = 8192;

    typedef struct packed {
        logic        arrived;
        logic [1:0]  goal_index;
        logic [14:0] ang_vel;
        logic [10:0] lin_vel;
    } command_t;

    // Goal poses in Q3.12.
    localparam longint GOAL_X[4] = '{16384, 20480, 16384, 4096};
    localparam longint GOAL_Y[4] = '{0, -8192, -12288, -4096};
    localparam longint GOAL_H[4] = '{0, -HALF_PI_Q, -PI_Q, PI_Q};
    localparam longint ATAN_STEP[11] = '{
        843314857, 497837829, 263043836, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576
    };

    longint   kp, ka, kb, tol;
    int       goal_idx;
    command_t expected_cmds[$];

    assign pending = expected_cmds.size();

    function automatic longint floor_sqrt(bit [63:0] n);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Vectoring CORDIC with the angle held in Q30, rounded to Q3.12.
    function automatic longint bearing_atan2(longint dy, longint dx);
        longint x, y, z, t, xs, ys, st;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = PI_Q30 / 2;
            end
            else
            begin
                t = x; x = -y; y = t; z = -(PI_Q30 / 2);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            st = (i < 11) ? ATAN_STEP[i] : (64'sd1 <<< (30 - i));
            if (y > 0)
            begin
                x = x + ys; y = y - xs; z = z + st;
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - st;
            end
        end
        return (z + (64'sd1 <<< 17)) >>> 18;
    endfunction

    function automatic longint wrap_pi(longint a);
        if (a > PI_Q)
            a = a - TWO_PI_Q;
        if (a < -PI_Q)
            a = a + TWO_PI_Q;
        return a;
    endfunction

    // Works out the command for one odometry word and advances the goal index on arrival.
    task automatic compute_command(input logic [47:0] d, output command_t c);
        longint x, y, h, dx, dy, dth, rho, alpha, beta, v, w;
        logic   hit;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        h = longint'($signed(d[46:32]));
        dx = GOAL_X[goal_idx] - x;
        dy = GOAL_Y[goal_idx] - y;
        dth = GOAL_H[goal_idx] - h;
        rho = floor_sqrt(64'(dx * dx + dy * dy));
        alpha = wrap_pi(bearing_atan2(dy, dx) - h);
        beta = wrap_pi(dth - alpha);
        v = (kp * rho + 2048) >>> 12;
        w = (ka * alpha + kb * beta + 2048) >>> 12;
        hit = 1'b0;
        if (v >= V_TRIP) v = V_SET;
        if (v <= -V_TRIP) v = -V_SET;
        if (w >= W_TRIP) w = W_SET;
        if (w <= -W_TRIP) w = -W_SET;
        if (dx > -tol && dx < tol && dy > -tol && dy < tol)
        begin
            v = 0;
            if (dth > -2 * tol && dth < 2 * tol)
            begin
                w = 0;
                hit = 1'b1;
                if (goal_idx < 3)
                    goal_idx++;
            end
        end
        c.lin_vel = v[10:0];
        c.ang_vel = w[14:0];
        c.goal_index = goal_idx[1:0];
        c.arrived = hit;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (errors < 40)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // One block handles config, input and output at each edge, in that order.
    always @(posedge clk or negedge rst_n)
    begin
        command_t c;
        command_t got;
        if (!rst_n)
        begin
            kp = 1638;
            ka = 4096;
            kb = -1229;
            tol = 410;
            goal_idx = 0;
            errors = 0;
            expected_cmds.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KP:  kp = longint'($signed(cfg_data));
                    REG_KA:  ka = longint'($signed(cfg_data));
                    REG_KB:  kb = longint'($signed(cfg_data));
                    REG_TOL: tol = longint'(cfg_data[14:0]);
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                compute_command(s_axis_tdata, c);
                expected_cmds.push_back(c);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[28:0];
                if (expected_cmds.size() == 0)
                    report_mismatch("unexpected word", longint'(m_axis_tdata), 0);
                else
                begin
                    c = expected_cmds.pop_front();
                    if (got.lin_vel !== c.lin_vel)
                        report_mismatch("lin_vel", $signed(got.lin_vel), $signed(c.lin_vel));
                    if (got.ang_vel !== c.ang_vel)
                        report_mismatch("ang_vel", $signed(got.ang_vel), $signed(c.ang_vel));
                    if (got.goal_index !== c.goal_index)
                        report_mismatch("goal_index", got.goal_index, c.goal_index);
                    if (got.arrived !== c.arrived)
                        report_mismatch("arrived", got.arrived, c.arrived);
                end
            end
        end
    end
endmodule

@@ verif/polar_pose_controller_tb.sv @@
// Testbench top for the pose controller: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module polar_pose_controller_tb;
    import ppc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT = 150;
    localparam int HOLD_LEN = 400;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;    // pos_x[15:0], pos_y[31:16], heading[46:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // lin_vel[10:0], ang_vel[25:11], goal_index[27:26], arrived[28]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    int          idle_phase;
    int          words_sent;
    int          cycles;
    int          hold_left;
    bit          hold_done;

    // Goal poses, used to aim stimulus near each waypoint.
    localparam int GX[4] = '{16384, 20480, 16384, 4096};
    localparam int GY[4] = '{0, -8192, -12288, -4096};
    localparam int GH[4] = '{0, -6434, -12868, 12868};

    polar_pose_controller uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    polar_pose_controller_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always #5 clk = ~clk;

    // Receiver: random stalls by phase, plus one long hold-off.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && words_sent >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else if (idle_phase == 0)
            m_axis_tready <= ($urandom_range(0, 99) >= 71);
        else if (idle_phase == 1)
            m_axis_tready <= ($urandom_range(0, 99) >= 9);
        else
            m_axis_tready <= 1'b1;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [15:0] x, input logic [15:0] y, input logic [14:0] h);
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 9 : (idle_phase == 1) ? 71 : 0;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < gap_pct / 2)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, h, y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
    endtask

    // Waits until all commands are back, then writes the three gains and the tolerance.
    task automatic write_gains(input logic [15:0] vkp, input logic [15:0] vka,
                               input logic [15:0] vkb, input logic [15:0] vtol);
        logic [15:0] vals[4];
        logic [1:0]  regs[4];
        s_axis_tvalid <= 1'b0;
        vals = '{vkp, vka, vkb, vtol};
        regs = '{REG_KP, REG_KA, REG_KB, REG_TOL};
        // Let the checker see the last accepted word before polling the count.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Half the samples near a waypoint, the rest raw noise or heading extremes.
    task automatic send_random();
        int k, sel;
        sel = $urandom_range(0, 9);
        k = $urandom_range(0, 3);
        if (sel < 5)
            send_word(16'(GX[k] + $signed($urandom_range(0, 1200)) - 600),
                      16'(GY[k] + $signed($urandom_range(0, 1200)) - 600),
                      15'(GH[k] + $signed($urandom_range(0, 2000)) - 1000));
        else if (sel < 8)
            send_word(16'($urandom), 16'($urandom), 15'($urandom));
        else
            send_word(16'($urandom), 16'($urandom),
                      ($urandom_range(0, 1) != 0) ? 15'(12868) : 15'(-12868));
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_KP;
        cfg_data = '0;
        idle_phase = 0;
        words_sent = 0;
        cycles = 0;
        hold_left = 0;
        hold_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, zero vector at the goal, then each goal in order.
        send_word(16'h8000, 16'h8000, 15'h4000);
        send_word(16'h7FFF, 16'h7FFF, 15'h3FFF);
        send_word(16'h8000, 16'h7FFF, 15'(12868));
        send_word(16'h7FFF, 16'h8000, 15'(-12868));
        send_word(16'h0000, 16'h0000, 15'h0000);
        send_word(16'hFFFF, 16'h0000, 15'h7FFF);
        send_word(16'(16384), 16'h0000, 15'(5000));
        send_word(16'(20000), 16'(300), 15'(-3000));
        send_word(16'(16384), 16'h0000, 15'h0000);
        send_word(16'(16000), 16'(-8000), 15'(-6434));
        send_word(16'(20480), 16'(-8192), 15'(-6434));
        send_word(16'(16384), 16'(-12288), 15'(-12868));
        send_word(16'(4096), 16'(-4096), 15'(12868));
        send_word(16'(4096), 16'(-4096), 15'(12868));
        send_word(16'(4300), 16'(-3900), 15'(12000));
        send_word(16'(9000), 16'(5000), 15'(-12868));

        for (int p = 0; p < 6; p++)
        begin
            idle_phase = p / 2;
            case (p)
                0: write_gains(16'd1638, 16'd4096, 16'hFB33, 16'd410);
                1: write_gains(16'h7FFF, 16'h8000, 16'h7FFF, 16'd0);
                2: write_gains(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
                5: write_gains(16'd1638, 16'd4096, 16'hFB33, 16'd410);
                default: write_gains(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom_range(0, 2000)));
            endcase
            for (int n = 0; n < 240; n++)
                send_random();
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
